// ===== rtl/core/ebm_pkg.sv =====
// ebm_pkg: shared types, constants and helpers of the event binding match table
`timescale 1ns / 1ps
package ebm_pkg;

    localparam int TABLE_DEPTH      = 32;
    localparam int CONTROLLER_COUNT = 128;
    localparam int LEVEL_CHANNELS   = 17;
    localparam int LEVEL_DEPTH      = LEVEL_CHANNELS * CONTROLLER_COUNT;
    localparam int TAB_AW           = $clog2(TABLE_DEPTH);
    localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
    localparam int LVL_AW           = $clog2(LEVEL_DEPTH);
    localparam int CC_W             = $clog2(CONTROLLER_COUNT);

    localparam logic [15:0] HALF_LEVEL = 16'd16384;
    localparam logic [15:0] FULL_LEVEL = 16'd32768;
    localparam logic [22:0] SCALE_MUL  = 23'd4227331;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_REMOVE   = 4'd1,
        OP_KEY_DOWN = 4'd2,
        OP_KEY_UP   = 4'd3,
        OP_NOTE_ON  = 4'd4,
        OP_NOTE_OFF = 4'd5,
        OP_CC       = 4'd6,
        OP_CLEAR    = 4'd7,
        OP_QUERY    = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_NOTE = 2'd1,
        KIND_CC   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_LRD,
        ST_LMUL,
        ST_LADD,
        ST_QOUT
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic        en;
        logic [1:0]  kind;
        logic [15:0] code;
        logic [2:0]  mods;
        logic [4:0]  chan;
        logic        mom;
        logic        rel;
        logic [15:0] step;
    } t_entry;

    // (v * 32768 + 63) / 127 through a reciprocal, exact for 7-bit v
    function automatic logic [15:0] scale127(input logic [6:0] v);
        logic [21:0] x;
        logic [44:0] p;
        begin
            x = {v, 15'd0} + 22'd63;
            p = x * SCALE_MUL;
            return p[44:29];
        end
    endfunction

    function automatic logic entry_match(input t_entry e, input logic [1:0] kind,
                                         input logic [15:0] code,
                                         input logic [2:0] mods,
                                         input logic [4:0] ch,
                                         input logic only_mom);
        logic side;
        begin
            if (kind == KIND_KEY) begin
                side = (e.mods == mods);
            end else begin
                side = (e.chan == 5'd0) || (e.chan == ch);
            end
            return e.en && (e.kind == kind) && (!only_mom || e.mom) &&
                   (e.code == code) && side;
        end
    endfunction

endpackage

// ===== rtl/core/ebm_ram.sv =====
// ebm_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module ebm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/event_binding_match_table.sv =====
// event_binding_match_table: ordered binding table with event matching and relative levels
`timescale 1ns / 1ps
// One request at a time: start is taken while busy is low, and one result
// follows on o_valid for a single cycle; the receiver cannot stall it. Add,
// capture, clear and unused opcodes answer in the cycle after acceptance.
// Events, key-up/note-off and remove scan the binding memory one entry per
// cycle through its registered read port until the first match or the last
// entry; a relative CC then steps through ST_LRD, ST_LMUL and ST_LADD for the
// read-multiply-write of the level memory, and a query through ST_LRD and
// ST_QOUT. Remove then closes the gap by copying the later entries down, one
// per cycle. Clear and reset sweep the 2176-entry level memory, one entry
// per cycle with busy high. The configuration port is always ready.
module event_binding_match_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_opcode,
    input  logic [15:0] i_entry_id,
    input  logic [1:0]  i_source_kind,
    input  logic [15:0] i_event_code,
    input  logic [2:0]  i_modifiers,
    input  logic [4:0]  i_channel,
    input  logic [6:0]  i_data_value,
    input  logic        i_momentary,
    input  logic        i_cc_relative,
    input  logic [15:0] i_step_size,
    input  logic        i_enabled,
    output logic        o_valid,
    output logic        o_handled,
    output logic [15:0] o_result_id,
    output logic [15:0] o_action_value,
    output logic        o_captured,
    output logic [1:0]  o_captured_kind,
    output logic        o_table_full
);

    ebm_pkg::t_state r_state, n_state;
    logic [ebm_pkg::CNT_W-1:0]  r_count, n_count;
    logic [15:0]                r_next_id, n_next_id;
    logic                       r_capture;
    logic [ebm_pkg::LVL_AW-1:0] r_clr, n_clr;
    logic [3:0]                 r_op;
    logic [15:0]                r_id, r_code;
    logic [2:0]                 r_mods;
    logic [4:0]                 r_ch;
    logic [6:0]                 r_val;
    logic [ebm_pkg::CNT_W-1:0]  r_sidx, n_sidx;
    logic                       r_pend, n_pend;
    logic [ebm_pkg::TAB_AW-1:0] r_pidx, n_pidx;
    logic [15:0]                r_step, n_step;
    logic [15:0]                r_lvl, n_lvl;
    logic signed [24:0]         r_prod, n_prod;
    logic                       r_valid, n_valid;
    logic                       r_handled, n_handled;
    logic [15:0]                r_rid, n_rid;
    logic [15:0]                r_act, n_act;
    logic                       r_cap, n_cap;
    logic [1:0]                 r_ckind, n_ckind;
    logic                       r_full, n_full;

    logic                       acc;
    logic                       in_cap_ev, in_cap_rel;
    ebm_pkg::t_entry            tab_rdata, tab_wdata, new_entry;
    logic                       tab_we;
    logic [ebm_pkg::TAB_AW-1:0] tab_waddr;
    logic [15:0]                lvl_rdata, lvl_wdata;
    logic                       lvl_we, li_ok;
    logic [ebm_pkg::LVL_AW-1:0] lvl_idx, lvl_waddr;
    logic [1:0]                 ev_kind;
    logic                       only_mom, is_remove, hit, miss, issue;
    logic signed [25:0]         sum;
    logic [15:0]                clamped;
    logic signed [7:0]          diff;

    assign acc         = i_start && (r_state == ebm_pkg::ST_IDLE);
    assign o_busy      = (r_state != ebm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_cap_ev   = r_capture && (i_opcode == ebm_pkg::OP_KEY_DOWN ||
                         i_opcode == ebm_pkg::OP_NOTE_ON || i_opcode == ebm_pkg::OP_CC);
    assign in_cap_rel  = r_capture && (i_opcode == ebm_pkg::OP_KEY_UP ||
                         i_opcode == ebm_pkg::OP_NOTE_OFF);

    assign new_entry = '{id: r_next_id, en: i_enabled, kind: i_source_kind,
                         code: i_event_code, mods: i_modifiers, chan: i_channel,
                         mom: i_momentary, rel: i_cc_relative, step: i_step_size};

    // binding memory
    assign tab_we = (acc && i_opcode == ebm_pkg::OP_ADD &&
                     r_count < ebm_pkg::CNT_W'(ebm_pkg::TABLE_DEPTH)) ||
                    (r_state == ebm_pkg::ST_SHIFT && r_pend);
    assign tab_waddr = (r_state == ebm_pkg::ST_SHIFT) ? r_pidx - 1'b1
                                                      : r_count[ebm_pkg::TAB_AW-1:0];
    assign tab_wdata = (r_state == ebm_pkg::ST_SHIFT) ? tab_rdata : new_entry;

    ebm_ram #(
        .WIDTH($bits(ebm_pkg::t_entry)),
        .DEPTH(ebm_pkg::TABLE_DEPTH)
    ) u_tab (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(tab_waddr),
        .i_wdata(tab_wdata),
        .i_raddr(r_sidx[ebm_pkg::TAB_AW-1:0]),
        .o_rdata(tab_rdata)
    );

    // level memory
    assign li_ok   = (r_ch < 5'(ebm_pkg::LEVEL_CHANNELS)) &&
                     (32'(r_code) < ebm_pkg::CONTROLLER_COUNT);
    assign lvl_idx = ebm_pkg::LVL_AW'(32'(r_ch) * ebm_pkg::CONTROLLER_COUNT +
                                      32'(r_code[ebm_pkg::CC_W-1:0]));
    assign diff    = $signed({1'b0, r_val}) - 8'sd64;
    assign sum     = $signed({10'd0, r_lvl}) + $signed({r_prod[24], r_prod});
    always_comb begin
        if (sum < 26'sd0) begin
            clamped = 16'd0;
        end else if (sum > $signed({10'd0, ebm_pkg::FULL_LEVEL})) begin
            clamped = ebm_pkg::FULL_LEVEL;
        end else begin
            clamped = sum[15:0];
        end
    end
    assign lvl_we    = (r_state == ebm_pkg::ST_CLR) ||
                       (r_state == ebm_pkg::ST_LADD && li_ok);
    assign lvl_waddr = (r_state == ebm_pkg::ST_CLR) ? r_clr : lvl_idx;
    assign lvl_wdata = (r_state == ebm_pkg::ST_CLR) ? ebm_pkg::HALF_LEVEL : clamped;

    ebm_ram #(
        .WIDTH(16),
        .DEPTH(ebm_pkg::LEVEL_DEPTH)
    ) u_lvl (
        .i_clk  (i_clk),
        .i_we   (lvl_we),
        .i_waddr(lvl_waddr),
        .i_wdata(lvl_wdata),
        .i_raddr(lvl_idx),
        .o_rdata(lvl_rdata)
    );

    // scan compare
    always_comb begin
        unique case (r_op)
            ebm_pkg::OP_KEY_DOWN, ebm_pkg::OP_KEY_UP:   ev_kind = ebm_pkg::KIND_KEY;
            ebm_pkg::OP_NOTE_ON, ebm_pkg::OP_NOTE_OFF: ev_kind = ebm_pkg::KIND_NOTE;
            default:                                   ev_kind = ebm_pkg::KIND_CC;
        endcase
    end
    assign only_mom  = (r_op == ebm_pkg::OP_KEY_UP) || (r_op == ebm_pkg::OP_NOTE_OFF);
    assign is_remove = (r_op == ebm_pkg::OP_REMOVE);
    assign hit  = r_pend && (is_remove ? (tab_rdata.id == r_id)
                  : ebm_pkg::entry_match(tab_rdata, ev_kind, r_code, r_mods, r_ch, only_mom));
    assign issue = (r_sidx < r_count);
    assign miss  = !r_pend && !issue;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ebm_pkg::ST_CLR: begin
                if (r_clr == ebm_pkg::LVL_AW'(ebm_pkg::LEVEL_DEPTH - 1)) begin
                    n_state = ebm_pkg::ST_IDLE;
                end
            end
            ebm_pkg::ST_IDLE: begin
                if (i_start) begin
                    priority case (i_opcode)
                        ebm_pkg::OP_REMOVE: n_state = ebm_pkg::ST_SCAN;
                        ebm_pkg::OP_KEY_DOWN, ebm_pkg::OP_NOTE_ON, ebm_pkg::OP_CC,
                        ebm_pkg::OP_KEY_UP, ebm_pkg::OP_NOTE_OFF: begin
                            n_state = r_capture ? ebm_pkg::ST_IDLE : ebm_pkg::ST_SCAN;
                        end
                        ebm_pkg::OP_CLEAR:  n_state = ebm_pkg::ST_CLR;
                        ebm_pkg::OP_QUERY:  n_state = ebm_pkg::ST_LRD;
                        default:            n_state = ebm_pkg::ST_IDLE;
                    endcase
                end
            end
            ebm_pkg::ST_SCAN: begin
                if (hit) begin
                    if (is_remove) begin
                        n_state = ebm_pkg::ST_SHIFT;
                    end else if (r_op == ebm_pkg::OP_CC && tab_rdata.rel) begin
                        n_state = ebm_pkg::ST_LRD;
                    end else begin
                        n_state = ebm_pkg::ST_IDLE;
                    end
                end else if (miss) begin
                    n_state = ebm_pkg::ST_IDLE;
                end
            end
            ebm_pkg::ST_SHIFT: begin
                if (miss) begin
                    n_state = ebm_pkg::ST_IDLE;
                end
            end
            ebm_pkg::ST_LRD: begin
                n_state = (r_op == ebm_pkg::OP_QUERY) ? ebm_pkg::ST_QOUT : ebm_pkg::ST_LMUL;
            end
            ebm_pkg::ST_LMUL: n_state = ebm_pkg::ST_LADD;
            ebm_pkg::ST_LADD: n_state = ebm_pkg::ST_IDLE;
            ebm_pkg::ST_QOUT: n_state = ebm_pkg::ST_IDLE;
            default:          n_state = ebm_pkg::ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_count   = r_count;
        n_next_id = r_next_id;
        n_clr     = r_clr;
        n_sidx    = r_sidx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_step    = r_step;
        n_lvl     = r_lvl;
        n_prod    = r_prod;
        n_valid   = 1'b0;
        n_handled = r_handled;
        n_rid     = r_rid;
        n_act     = r_act;
        n_cap     = r_cap;
        n_ckind   = r_ckind;
        n_full    = r_full;
        unique case (r_state)
            ebm_pkg::ST_CLR: begin
                n_clr = r_clr + 1'b1;
            end
            ebm_pkg::ST_IDLE: begin
                n_sidx = '0;
                n_pend = 1'b0;
                n_clr  = '0;
                if (acc) begin
                    n_handled = 1'b0;
                    n_rid     = 16'd0;
                    n_act     = 16'd0;
                    n_cap     = 1'b0;
                    n_ckind   = 2'd0;
                    n_full    = 1'b0;
                    if (i_opcode == ebm_pkg::OP_ADD) begin
                        n_valid = 1'b1;
                        if (r_count < ebm_pkg::CNT_W'(ebm_pkg::TABLE_DEPTH)) begin
                            n_rid     = r_next_id;
                            n_next_id = r_next_id + 16'd1;
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end else if (in_cap_ev) begin
                        n_valid   = 1'b1;
                        n_handled = 1'b1;
                        n_cap     = 1'b1;
                        if (i_opcode == ebm_pkg::OP_KEY_DOWN) begin
                            n_ckind = ebm_pkg::KIND_KEY;
                        end else if (i_opcode == ebm_pkg::OP_NOTE_ON) begin
                            n_ckind = ebm_pkg::KIND_NOTE;
                        end else begin
                            n_ckind = ebm_pkg::KIND_CC;
                        end
                    end else if (in_cap_rel) begin
                        n_valid = 1'b1;
                    end else if (i_opcode == ebm_pkg::OP_CLEAR) begin
                        n_valid = 1'b1;
                        n_count = '0;
                    end else if (i_opcode > ebm_pkg::OP_QUERY) begin
                        n_valid = 1'b1;
                    end
                end
            end
            ebm_pkg::ST_SCAN, ebm_pkg::ST_SHIFT: begin
                if (issue) begin
                    n_pidx = r_sidx[ebm_pkg::TAB_AW-1:0];
                    n_sidx = r_sidx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_state == ebm_pkg::ST_SHIFT) begin
                    if (miss) begin
                        n_count = r_count - 1'b1;
                    end
                end else if (hit) begin
                    n_handled = 1'b1;
                    n_rid     = tab_rdata.id;
                    n_step    = tab_rdata.step;
                    if (is_remove) begin
                        n_valid = 1'b1;
                        n_rid   = 16'd0;
                        n_sidx  = ebm_pkg::CNT_W'(r_pidx) + 1'b1;
                        n_pend  = 1'b0;
                    end else if (r_op == ebm_pkg::OP_KEY_DOWN) begin
                        n_valid = 1'b1;
                        n_act   = ebm_pkg::FULL_LEVEL;
                    end else if (only_mom) begin
                        n_valid = 1'b1;
                    end else if (r_op == ebm_pkg::OP_NOTE_ON || !tab_rdata.rel) begin
                        n_valid = 1'b1;
                        n_act   = ebm_pkg::scale127(r_val);
                    end
                end else if (miss) begin
                    n_valid = 1'b1;
                end
            end
            ebm_pkg::ST_LRD: begin
            end
            ebm_pkg::ST_LMUL: begin
                n_lvl  = li_ok ? lvl_rdata : ebm_pkg::HALF_LEVEL;
                n_prod = diff * $signed({1'b0, r_step});
            end
            ebm_pkg::ST_LADD: begin
                n_valid = 1'b1;
                n_act   = clamped;
            end
            ebm_pkg::ST_QOUT: begin
                n_valid = 1'b1;
                n_act   = li_ok ? lvl_rdata : ebm_pkg::HALF_LEVEL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ebm_pkg::ST_CLR;
            r_count   <= '0;
            r_next_id <= 16'd1;
            r_capture <= 1'b0;
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_sidx    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_clr     <= n_clr;
            r_pend    <= n_pend;
            r_sidx    <= n_sidx;
            r_valid   <= n_valid;
            if (i_cfg_valid) begin
                r_capture <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op   <= i_opcode;
            r_id   <= i_entry_id;
            r_code <= i_event_code;
            r_mods <= i_modifiers;
            r_ch   <= i_channel;
            r_val  <= i_data_value;
        end
        r_pidx    <= n_pidx;
        r_step    <= n_step;
        r_lvl     <= n_lvl;
        r_prod    <= n_prod;
        r_handled <= n_handled;
        r_rid     <= n_rid;
        r_act     <= n_act;
        r_cap     <= n_cap;
        r_ckind   <= n_ckind;
        r_full    <= n_full;
    end

    assign o_valid         = r_valid;
    assign o_handled       = r_handled;
    assign o_result_id     = r_rid;
    assign o_action_value  = r_act;
    assign o_captured      = r_cap;
    assign o_captured_kind = r_ckind;
    assign o_table_full    = r_full;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ebm_pkg::CNT_W'(ebm_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");
    a_full_only_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (r_count == ebm_pkg::CNT_W'(ebm_pkg::TABLE_DEPTH)))
        else $error("table full reported below depth");
    a_capture_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_captured) |-> (o_handled && o_result_id == 16'd0))
        else $error("capture result malformed");
    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action_value <= ebm_pkg::FULL_LEVEL))
        else $error("action value above one");
`endif

endmodule
